// ===== rtl/skt_pkg.sv =====
// skt_pkg: action and status codes and shared types of the sorted key table
// used by the channel interfaces, the cell and the top level
`default_nettype none

package skt_pkg;

    localparam int TREE_WIDTH = 8;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // lookup token control travelling down the cell chain
    typedef struct packed {
        logic valid;
        logic hit;
    } tok_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/skt_if.sv =====
// skt_if: request and response channels of the sorted key table
// depends on skt_pkg for the tree field width
`default_nettype none

interface skt_req_if #(
    parameter int KEY_WIDTH    = 16,
    parameter int OFFSET_WIDTH = 32
);
    import skt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic [KEY_WIDTH-1:0]    key;
    logic [OFFSET_WIDTH-1:0] entry_offset;
    logic [TREE_WIDTH-1:0]   entry_tree;

    modport source (output valid, action, key, entry_offset, entry_tree, input ready);
    modport sink (input valid, action, key, entry_offset, entry_tree, output ready);
endinterface

interface skt_rsp_if #(
    parameter int OFFSET_WIDTH = 32,
    parameter int COUNT_WIDTH  = 7
);
    import skt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [OFFSET_WIDTH-1:0] found_offset;
    logic [TREE_WIDTH-1:0]   found_tree;
    logic [COUNT_WIDTH-1:0]  entry_count;

    modport source (output valid, status, found_offset, found_tree, entry_count,
                    input ready);
    modport sink (input valid, status, found_offset, found_tree, entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/skt_cell.sv =====
// skt_cell: one entry of the sorted table with its insert shift and lookup stage
// depends on skt_pkg for the tree width and token control type
`default_nettype none

module skt_cell #(
    parameter int INDEX        = 0,
    parameter int KEY_WIDTH    = 16,
    parameter int OFFSET_WIDTH = 32,
    parameter int COUNT_WIDTH  = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [COUNT_WIDTH-1:0]        count,
    input  wire logic                          ins_en,
    input  wire logic [KEY_WIDTH-1:0]          ins_key,
    input  wire logic [OFFSET_WIDTH-1:0]       ins_offset,
    input  wire logic [skt_pkg::TREE_WIDTH-1:0] ins_tree,
    input  wire logic                          prev_ge,
    input  wire logic [KEY_WIDTH-1:0]          prev_key,
    input  wire logic [OFFSET_WIDTH-1:0]       prev_offset,
    input  wire logic [skt_pkg::TREE_WIDTH-1:0] prev_tree,
    output logic                               ge,
    output logic [KEY_WIDTH-1:0]               key,
    output logic [OFFSET_WIDTH-1:0]            offset,
    output logic [skt_pkg::TREE_WIDTH-1:0]     tree,
    input  wire logic [KEY_WIDTH-1:0]          search_key,
    input  wire skt_pkg::tok_ctl_t             prev_tok,
    input  wire logic [OFFSET_WIDTH-1:0]       prev_tok_offset,
    input  wire logic [skt_pkg::TREE_WIDTH-1:0] prev_tok_tree,
    output skt_pkg::tok_ctl_t                  tok,
    output logic [OFFSET_WIDTH-1:0]            tok_offset,
    output logic [skt_pkg::TREE_WIDTH-1:0]     tok_tree
);
    import skt_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] MY_INDEX = COUNT_WIDTH'(INDEX);

    logic [KEY_WIDTH-1:0]    key_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [TREE_WIDTH-1:0]   tree_reg;
    tok_ctl_t                tok_reg, tok_next;
    logic [OFFSET_WIDTH-1:0] tok_offset_reg, tok_offset_next;
    logic [TREE_WIDTH-1:0]   tok_tree_reg, tok_tree_next;
    logic                    occupied;
    logic                    at_end;
    logic                    match;

    assign occupied = MY_INDEX < count;
    assign at_end   = MY_INDEX == count;
    assign ge       = occupied && (key_reg >= ins_key);
    assign match    = occupied && (key_reg == search_key);

    assign key    = key_reg;
    assign offset = offset_reg;
    assign tree   = tree_reg;

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            if (prev_ge)
            begin
                key_reg    <= prev_key;
                offset_reg <= prev_offset;
                tree_reg   <= prev_tree;
            end
            else if (ge || at_end)
            begin
                key_reg    <= ins_key;
                offset_reg <= ins_offset;
                tree_reg   <= ins_tree;
            end
        end
    end

    always_comb
    begin
        tok_next.valid  = prev_tok.valid;
        tok_next.hit    = prev_tok.hit;
        tok_offset_next = prev_tok_offset;
        tok_tree_next   = prev_tok_tree;
        if (prev_tok.valid && !prev_tok.hit && match)
        begin
            tok_next.hit    = 1'b1;
            tok_offset_next = offset_reg;
            tok_tree_next   = tree_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_offset_reg <= tok_offset_next;
        tok_tree_reg   <= tok_tree_next;
    end

    assign tok        = tok_reg;
    assign tok_offset = tok_offset_reg;
    assign tok_tree   = tok_tree_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_key_table_core.sv =====
// sorted_key_table_core: chain of table cells, fill count and response register
// depends on skt_pkg, skt_if and skt_cell
//
//   channel  dir  carries
//   req      in   action, key, entry_offset, entry_tree
//   rsp      out  status, found_offset, found_tree, entry_count
//
// clear and insert finish at the accepting edge: the cells shift in parallel and
// the response is registered there. a lookup answers once the token, walking one
// cell per cycle down the chain, has passed the last cell.
// req.ready is low during a lookup walk and while a response waits untaken.
// rst_n empties the table and the response register; no clearing pass.
`default_nettype none

module sorted_key_table_core #(
    parameter int CAPACITY     = 64,
    parameter int KEY_WIDTH    = 16,
    parameter int OFFSET_WIDTH = 32,
    parameter int COUNT_WIDTH  = 7
) (
    input  wire logic clk,
    input  wire logic rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);
    import skt_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(CAPACITY);

    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                    busy_reg, busy_next;
    logic                    start_reg, start_next;
    logic [KEY_WIDTH-1:0]    search_key_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic [OFFSET_WIDTH-1:0] out_offset_reg, out_offset_next;
    logic [TREE_WIDTH-1:0]   out_tree_reg, out_tree_next;
    logic [COUNT_WIDTH-1:0]  out_count_reg, out_count_next;
    logic                    accept;
    logic                    ins_en;

    logic                    ge_chain     [0:CAPACITY];
    logic [KEY_WIDTH-1:0]    key_chain    [0:CAPACITY];
    logic [OFFSET_WIDTH-1:0] offset_chain [0:CAPACITY];
    logic [TREE_WIDTH-1:0]   tree_chain   [0:CAPACITY];
    tok_ctl_t                tok_chain    [0:CAPACITY];
    logic [OFFSET_WIDTH-1:0] tok_off_chain  [0:CAPACITY];
    logic [TREE_WIDTH-1:0]   tok_tree_chain [0:CAPACITY];

    assign req.ready = !busy_reg && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign ge_chain[0]       = 1'b0;
    assign key_chain[0]      = '0;
    assign offset_chain[0]   = '0;
    assign tree_chain[0]     = '0;
    assign tok_chain[0].valid = start_reg;
    assign tok_chain[0].hit   = 1'b0;
    assign tok_off_chain[0]  = '0;
    assign tok_tree_chain[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        skt_cell #(
            .INDEX        (i),
            .KEY_WIDTH    (KEY_WIDTH),
            .OFFSET_WIDTH (OFFSET_WIDTH),
            .COUNT_WIDTH  (COUNT_WIDTH)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .count           (count_reg),
            .ins_en          (ins_en),
            .ins_key         (req.key),
            .ins_offset      (req.entry_offset),
            .ins_tree        (req.entry_tree),
            .prev_ge         (ge_chain[i]),
            .prev_key        (key_chain[i]),
            .prev_offset     (offset_chain[i]),
            .prev_tree       (tree_chain[i]),
            .ge              (ge_chain[i+1]),
            .key             (key_chain[i+1]),
            .offset          (offset_chain[i+1]),
            .tree            (tree_chain[i+1]),
            .search_key      (search_key_reg),
            .prev_tok        (tok_chain[i]),
            .prev_tok_offset (tok_off_chain[i]),
            .prev_tok_tree   (tok_tree_chain[i]),
            .tok             (tok_chain[i+1]),
            .tok_offset      (tok_off_chain[i+1]),
            .tok_tree        (tok_tree_chain[i+1])
        );
    end

    always_comb
    begin
        count_next      = count_reg;
        busy_next       = busy_reg;
        start_next      = 1'b0;
        ins_en          = 1'b0;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        out_tree_next   = out_tree_reg;
        out_count_next  = out_count_reg;

        if (accept)
        begin
            out_status_next = ST_OK;
            out_offset_next = '0;
            out_tree_next   = '0;
            case (req.action)
                ACT_CLEAR:
                begin
                    count_next     = '0;
                    out_valid_next = 1'b1;
                end
                ACT_INSERT:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == FULL_COUNT)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        ins_en     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_LOOKUP:
                begin
                    busy_next  = 1'b1;
                    start_next = 1'b1;
                end
                default:
                begin
                    out_valid_next = 1'b1;
                end
            endcase
            out_count_next = count_next;
        end
        else if (tok_chain[CAPACITY].valid)
        begin
            busy_next       = 1'b0;
            out_valid_next  = 1'b1;
            out_status_next = tok_chain[CAPACITY].hit ? ST_OK : ST_NOT_FOUND;
            out_offset_next = tok_off_chain[CAPACITY];
            out_tree_next   = tok_tree_chain[CAPACITY];
            out_count_next  = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            search_key_reg <= req.key;
        end
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        out_tree_reg   <= out_tree_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_offset = out_offset_reg;
    assign rsp.found_tree   = out_tree_reg;
    assign rsp.entry_count  = out_count_reg;

endmodule

`default_nettype wire
